@@ rtl/pewf_pkg.sv @@
`timescale 1ns / 1ps

package pewf_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int ENERGY_BITS   = 24;
    localparam int CODE_BITS     = 32;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = ENERGY_BITS;

    // commands
    localparam logic [1:0] CMD_CHECK = 2'd0;
    localparam logic [1:0] CMD_SET   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // filter modes (the unused code behaves as pass)
    localparam logic [1:0] MODE_PASS  = 2'd0;
    localparam logic [1:0] MODE_WHITE = 2'd1;
    localparam logic [1:0] MODE_BLACK = 2'd2;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GLOW   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GHIGH  = 2'd2;

    typedef struct packed {
        logic [1:0]                   command;
        logic signed [CODE_BITS-1:0]  particle_code;
        logic [ENERGY_BITS-1:0]       hit_energy;
        logic [ENERGY_BITS-1:0]       window_low;
        logic [ENERGY_BITS-1:0]       window_high;
    } in_item_t;

    typedef struct packed {
        logic accepted;
        logic status;
    } out_item_t;

    // query travelling along the row of cells
    typedef struct packed {
        logic                   active;
        logic [1:0]             cmd;
        logic [CODE_BITS-1:0]   code;
        logic [ENERGY_BITS-1:0] energy;
        logic [ENERGY_BITS-1:0] wlo;
        logic [ENERGY_BITS-1:0] whi;
        logic                   hit;
        logic                   hit_win;
        logic [IDX_W-1:0]       hit_idx;
        logic                   free_ok;
        logic [IDX_W-1:0]       free_idx;
    } tok_t;

    // table update broadcast to every cell
    typedef struct packed {
        logic                   en;
        logic                   clr;
        logic [IDX_W-1:0]       idx;
        logic [CODE_BITS-1:0]   code;
        logic [ENERGY_BITS-1:0] lo;
        logic [ENERGY_BITS-1:0] hi;
    } wr_t;

    // equal bounds pass all, lo < hi is an open interval, lo > hi a wrapped gap
    function automatic logic in_window(input logic [ENERGY_BITS-1:0] e,
                                       input logic [ENERGY_BITS-1:0] lo,
                                       input logic [ENERGY_BITS-1:0] hi);
        logic res;
        if (lo == hi) begin
            res = 1'b1;
        end else if (lo < hi) begin
            res = (e > lo) && (e < hi);
        end else begin
            res = (e > lo) || (e < hi);
        end
        return res;
    endfunction

endpackage

@@ rtl/particle_energy_window_filter.sv @@
`timescale 1ns / 1ps
// Channel   Ports                       Direction  Payload
// input     s_valid s_ready s_data      in         in_item_t (command, code, energy, window)
// result    m_valid m_ready m_data      out        out_item_t (accepted, status)
// config    cfg_we cfg_addr cfg_wdata   in         write only, index 0..2
//
// An item passes from its transfer to its result through the input register
// tok_in_reg, one register per table cell as the query walks the row, the staged
// result register pend_reg and the output register. One item is in the row at a
// time: a new transfer is taken only once the row is empty and nothing is staged.
// Reset (synchronous, aresetn low) empties the table, resets the configuration
// registers and clears the valid flags. A result waiting on m_ready does not block
// the next input transfer, but the staged result of that item then holds off any further one.

module particle_energy_window_filter import pewf_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    // configuration registers
    logic [1:0]             mode_reg;
    logic [ENERGY_BITS-1:0] glow_reg;
    logic [ENERGY_BITS-1:0] ghigh_reg;

    // control
    logic      inflight_reg;   // a query is in the row
    logic      pend_valid_reg; // result staged, waiting for the output register
    out_item_t pend_reg;
    out_item_t pend_next;
    logic      m_valid_reg;
    out_item_t m_data_reg;

    tok_t tok_in_reg;
    tok_t tok_chain [TABLE_ENTRIES];
    tok_t last_tok;
    wr_t  wr;
    logic [TABLE_ENTRIES-1:0] act_vec;

    logic s_fire;
    logic out_free;
    logic gwin;
    logic listed;

    assign s_ready  = !inflight_reg && !pend_valid_reg;
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign last_tok = tok_chain[TABLE_ENTRIES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_PASS;
            glow_reg  <= '0;
            ghigh_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_MODE:  mode_reg  <= cfg_wdata[1:0];
                CFG_GLOW:  glow_reg  <= cfg_wdata[ENERGY_BITS-1:0];
                CFG_GHIGH: ghigh_reg <= cfg_wdata[ENERGY_BITS-1:0];
                default: ;
            endcase
        end
    end

    // query entering the first cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_in_reg.active <= 1'b0;
        end else begin
            tok_in_reg.active <= s_fire;
        end
        if (s_fire) begin
            tok_in_reg.cmd      <= s_data.command;
            tok_in_reg.code     <= s_data.particle_code;
            tok_in_reg.energy   <= s_data.hit_energy;
            tok_in_reg.wlo      <= s_data.window_low;
            tok_in_reg.whi      <= s_data.window_high;
            tok_in_reg.hit      <= 1'b0;
            tok_in_reg.hit_win  <= 1'b0;
            tok_in_reg.hit_idx  <= '0;
            tok_in_reg.free_ok  <= 1'b0;
            tok_in_reg.free_idx <= '0;
        end
    end

    // row of table cells, one entry each
    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
        if (i == 0) begin : g_first
            pewf_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cell_idx (IDX_W'(i)),
                .tok_in   (tok_in_reg),
                .wr       (wr),
                .tok_out  (tok_chain[i])
            );
        end else begin : g_next
            pewf_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cell_idx (IDX_W'(i)),
                .tok_in   (tok_chain[i-1]),
                .wr       (wr),
                .tok_out  (tok_chain[i])
            );
        end
        assign act_vec[i] = tok_chain[i].active;
    end

    // end of row: decide the result and the table update
    always_comb begin
        gwin   = in_window(last_tok.energy, glow_reg, ghigh_reg);
        listed = last_tok.hit && last_tok.hit_win;
        pend_next = '0;
        wr.en   = 1'b0;
        wr.clr  = 1'b0;
        wr.idx  = last_tok.hit ? last_tok.hit_idx : last_tok.free_idx;
        wr.code = last_tok.code;
        wr.lo   = last_tok.wlo;
        wr.hi   = last_tok.whi;
        case (last_tok.cmd)
            CMD_CHECK: begin
                case (mode_reg)
                    MODE_WHITE: pend_next.accepted = gwin && listed;
                    MODE_BLACK: pend_next.accepted = gwin && !listed;
                    default:    pend_next.accepted = gwin;
                endcase
            end
            CMD_SET: begin
                // overwrite a listed code, else take the lowest free slot
                wr.en            = last_tok.active && (last_tok.hit || last_tok.free_ok);
                pend_next.status = !(last_tok.hit || last_tok.free_ok);
            end
            CMD_CLEAR: begin
                wr.clr = last_tok.active;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (s_fire) begin
                inflight_reg <= 1'b1;
            end else if (last_tok.active) begin
                inflight_reg <= 1'b0;
            end
            if (last_tok.active) begin
                pend_valid_reg <= 1'b1;
            end else if (pend_valid_reg && out_free) begin
                pend_valid_reg <= 1'b0;
            end
            if (pend_valid_reg && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (last_tok.active) begin
            pend_reg <= pend_next;
        end
        if (pend_valid_reg && out_free) begin
            m_data_reg <= pend_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // at most one query walks the row
    a_single_query: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({act_vec, tok_in_reg.active}) <= 1)
        else $error("more than one query in the cell row");

    // a query reaching the end of the row was accepted and is still owned
    a_end_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        last_tok.active |-> (inflight_reg && !pend_valid_reg))
        else $error("query left the row with no transfer outstanding");

    // a staged result moves on as soon as the output register is free
    a_pend_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_valid_reg && out_free) |=> (m_valid_reg && !pend_valid_reg))
        else $error("staged result did not move to the output register");

    // no table update without a query at the end of the row
    a_wr_qualified: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr.en || wr.clr) |-> last_tok.active)
        else $error("table update without a query");

endmodule

@@ rtl/pewf_cell.sv @@
`timescale 1ns / 1ps

module pewf_cell import pewf_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IDX_W-1:0] cell_idx,
    input  tok_t             tok_in,
    input  wr_t              wr,
    output tok_t             tok_out
);

    logic                   entry_valid_reg;
    logic [CODE_BITS-1:0]   entry_code_reg;
    logic [ENERGY_BITS-1:0] entry_low_reg;
    logic [ENERGY_BITS-1:0] entry_high_reg;
    tok_t                   tok_reg;
    tok_t                   tok_next;
    logic                   match;

    always_comb begin
        match    = tok_in.active && entry_valid_reg && (entry_code_reg == tok_in.code);
        tok_next = tok_in;
        if (match) begin
            tok_next.hit     = 1'b1;
            tok_next.hit_idx = cell_idx;
            tok_next.hit_win = in_window(tok_in.energy, entry_low_reg, entry_high_reg);
        end
        // first free slot seen from the low end wins
        if (tok_in.active && !tok_in.free_ok && !entry_valid_reg) begin
            tok_next.free_ok  = 1'b1;
            tok_next.free_idx = cell_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= 1'b0;
            tok_reg.active  <= 1'b0;
        end else begin
            tok_reg.active <= tok_next.active;
            if (wr.clr) begin
                entry_valid_reg <= 1'b0;
            end else if (wr.en && (wr.idx == cell_idx)) begin
                entry_valid_reg <= 1'b1;
            end
        end
        tok_reg.cmd      <= tok_next.cmd;
        tok_reg.code     <= tok_next.code;
        tok_reg.energy   <= tok_next.energy;
        tok_reg.wlo      <= tok_next.wlo;
        tok_reg.whi      <= tok_next.whi;
        tok_reg.hit      <= tok_next.hit;
        tok_reg.hit_win  <= tok_next.hit_win;
        tok_reg.hit_idx  <= tok_next.hit_idx;
        tok_reg.free_ok  <= tok_next.free_ok;
        tok_reg.free_idx <= tok_next.free_idx;
        if (wr.en && (wr.idx == cell_idx)) begin
            entry_code_reg <= wr.code;
            entry_low_reg  <= wr.lo;
            entry_high_reg <= wr.hi;
        end
    end

    assign tok_out = tok_reg;

endmodule

@@ tb/sv/tb_particle_energy_window_filter.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the particle energy window filter.
// Commands are queued up front by the stimulus process and fed to the input
// channel by a clocked driver; every input transfer is run through a local
// model of the filter table and the resulting verdict is queued. The result
// monitor pops the oldest verdict on each output transfer and compares the
// fields one by one.

module tb_particle_energy_window_filter;
    import pewf_pkg::*;

    // codes with no meaning to the block, still legal on the wires
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE  = 2'd3;
    localparam logic [1:0]            CMD_SPARE  = 2'd3;
    localparam logic [1:0]            MODE_SPARE = 2'd3;

    localparam logic [ENERGY_BITS-1:0] E_MAX     = '1;
    localparam logic [CODE_BITS-1:0]   CODE_MIN  = 32'h8000_0000;
    localparam logic [CODE_BITS-1:0]   CODE_MAX  = 32'h7FFF_FFFF;
    localparam int                     POOL_SIZE = 24;

    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 132;
    localparam int SETTLE_CYCLES  = TABLE_ENTRIES + 8;  // row walk plus output stages
    localparam int WATCHDOG_LIMIT = 2000;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;

    particle_energy_window_filter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Local copy of the filter: registers and particle table
    // ------------------------------------------------------------------
    logic [1:0]             flt_mode;
    logic [ENERGY_BITS-1:0] flt_glow;
    logic [ENERGY_BITS-1:0] flt_ghigh;
    logic                   slot_used [TABLE_ENTRIES];
    logic [CODE_BITS-1:0]   slot_code [TABLE_ENTRIES];
    logic [ENERGY_BITS-1:0] slot_lo   [TABLE_ENTRIES];
    logic [ENERGY_BITS-1:0] slot_hi   [TABLE_ENTRIES];

    in_item_t               cmd_queue[$];         // commands not yet driven
    out_item_t              pending_verdicts[$];  // verdicts awaiting their transfer
    logic [ENERGY_BITS-1:0] bound_pool[$];        // energies worth probing around
    logic [CODE_BITS-1:0]   code_pool [POOL_SIZE];
    out_item_t              verdict_head;

    int n_sent      = 0;  // items put on the input channel; ahead of n_items while one waits
    int gap_left    = 0;
    int s_calm_left = 0;
    int stall_left  = 0;
    int m_calm_left = 0;
    int idle_cycles = 0;
    int n_errors    = 0;
    int n_items     = 0;
    int n_results   = 0;
    int n_checks    = 0;
    int n_passed    = 0;
    int n_sets      = 0;
    int n_full      = 0;
    int n_clears    = 0;

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        n_errors++;
    endtask

    // Equal bounds let everything through; ordered bounds form an open
    // interval; reversed bounds leave out the gap between them.
    function automatic logic energy_ok(input logic [ENERGY_BITS-1:0] e,
                                       input logic [ENERGY_BITS-1:0] lo,
                                       input logic [ENERGY_BITS-1:0] hi);
        if (lo == hi) begin
            return 1'b1;
        end
        return (lo < hi) ? (e > lo && e < hi) : (e > lo || e < hi);
    endfunction

    // Verdict for one command; set and clear update the table copy.
    function automatic out_item_t filter_outcome(input in_item_t it);
        out_item_t r;
        int        found;
        int        free_slot;
        logic      listed_in;
        r         = '0;
        found     = -1;
        free_slot = -1;
        listed_in = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot_used[i] && slot_code[i] == it.particle_code && found < 0) begin
                found = i;
            end
            if (!slot_used[i] && free_slot < 0) begin
                free_slot = i;
            end
        end
        case (it.command)
            CMD_CHECK: begin
                n_checks++;
                if (found >= 0) begin
                    listed_in = energy_ok(it.hit_energy, slot_lo[found], slot_hi[found]);
                end
                if (energy_ok(it.hit_energy, flt_glow, flt_ghigh)) begin
                    case (flt_mode)
                        MODE_WHITE: r.accepted = listed_in;
                        MODE_BLACK: r.accepted = !listed_in;
                        default:    r.accepted = 1'b1;
                    endcase
                end
                if (r.accepted) begin
                    n_passed++;
                end
            end
            CMD_SET: begin
                n_sets++;
                // an existing code is overwritten in place, else lowest free slot
                if (found < 0) begin
                    found = free_slot;
                end
                if (found >= 0) begin
                    slot_used[found] = 1'b1;
                    slot_code[found] = it.particle_code;
                    slot_lo[found]   = it.window_low;
                    slot_hi[found]   = it.window_high;
                end else begin
                    r.status = 1'b1;
                    n_full++;
                end
            end
            CMD_CLEAR: begin
                n_clears++;
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    slot_used[i] = 1'b0;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Mostly back-to-back, some short gaps, the odd long one.
    function automatic int next_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            return 0;
        end
        if (roll < 94) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(12, 40);
    endfunction

    function automatic logic [CODE_BITS-1:0] pick_code();
        if ($urandom_range(0, 9) < 8) begin
            return code_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return $urandom();
    endfunction

    // Energies close to known bounds hit the open/closed corners of windows.
    function automatic logic [ENERGY_BITS-1:0] pick_energy();
        int                     roll;
        logic [ENERGY_BITS-1:0] b;
        roll = $urandom_range(0, 99);
        if (roll < 70 && bound_pool.size() > 0) begin
            b = bound_pool[$urandom_range(0, bound_pool.size() - 1)];
            case ($urandom_range(0, 2))
                0:       return b - 1'b1;
                1:       return b;
                default: return b + 1'b1;
            endcase
        end
        if (roll < 78) begin
            return ($urandom_range(0, 1) != 0) ? E_MAX : '0;
        end
        return ENERGY_BITS'($urandom());
    endfunction

    task automatic push_item(input logic [1:0]             cmd,
                             input logic [CODE_BITS-1:0]   code,
                             input logic [ENERGY_BITS-1:0] energy,
                             input logic [ENERGY_BITS-1:0] lo,
                             input logic [ENERGY_BITS-1:0] hi);
        in_item_t it;
        it.command       = cmd;
        it.particle_code = code;
        it.hit_energy    = energy;
        it.window_low    = lo;
        it.window_high   = hi;
        cmd_queue.push_back(it);
        if (cmd == CMD_SET) begin
            bound_pool.push_back(lo);
            bound_pool.push_back(hi);
            if (bound_pool.size() > 64) begin
                void'(bound_pool.pop_front());
                void'(bound_pool.pop_front());
            end
        end
    endtask

    // Called at a falling edge; the write lands on the next rising edge.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_MODE:  flt_mode  = val[1:0];
            CFG_GLOW:  flt_glow  = val;
            CFG_GHIGH: flt_ghigh = val;
            default: begin
            end
        endcase
        @(negedge aclk);
    endtask

    task automatic program_filter(input logic [1:0]             mode,
                                  input logic [ENERGY_BITS-1:0] lo,
                                  input logic [ENERGY_BITS-1:0] hi);
        write_reg(CFG_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_GLOW, lo);
        write_reg(CFG_GHIGH, hi);
        cfg_we <= 1'b0;
        bound_pool = {lo, hi};
    endtask

    // Stimulus holds off until every queued command has produced its verdict.
    task automatic drain();
        do begin
            @(negedge aclk);
        end while (cmd_queue.size() != 0 || n_sent != n_items ||
                   pending_verdicts.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Input driver: changes on the falling edge, one item held until transfer
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (n_sent == n_items) begin
            if (gap_left > 0) begin
                s_valid  <= 1'b0;
                gap_left = gap_left - 1;
            end else if (cmd_queue.size() > 0) begin
                s_data   <= cmd_queue.pop_front();
                s_valid  <= 1'b1;
                n_sent++;
                // calm stretches run with no gaps at all
                if (s_calm_left > 0) begin
                    s_calm_left = s_calm_left - 1;
                    gap_left    = 0;
                end else if ($urandom_range(0, 59) == 0) begin
                    s_calm_left = $urandom_range(10, 40);
                    gap_left    = 0;
                end else begin
                    gap_left = next_gap();
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Input transfer: predict the verdict at the edge that takes the item.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            pending_verdicts.push_back(filter_outcome(s_data));
            n_items++;
        end
    end

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the field-by-field compare
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if (m_calm_left > 0) begin
                m_calm_left = m_calm_left - 1;
            end else if ($urandom_range(0, 299) == 0) begin
                m_calm_left = $urandom_range(50, 300);
            end else begin
                stall_left = next_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch($sformatf("result %0d (accepted %b status %b) with none due",
                                          n_results, m_data.accepted, m_data.status));
            end else begin
                verdict_head = pending_verdicts.pop_front();
                if (m_data.accepted !== verdict_head.accepted) begin
                    report_mismatch($sformatf("result %0d: accepted %b, want %b",
                                              n_results, m_data.accepted,
                                              verdict_head.accepted));
                end
                if (m_data.status !== verdict_head.status) begin
                    report_mismatch($sformatf("result %0d: status %b, want %b",
                                              n_results, m_data.status,
                                              verdict_head.status));
                end
            end
            n_results++;
        end
    end

    // Watchdog: any transfer or register write counts as progress.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int                     roll;
        logic [1:0]             mode;
        logic [ENERGY_BITS-1:0] glo;
        logic [ENERGY_BITS-1:0] ghi;
        logic [ENERGY_BITS-1:0] wlo;
        logic [ENERGY_BITS-1:0] whi;

        // table copy and registers as after reset
        flt_mode  = MODE_PASS;
        flt_glow  = '0;
        flt_ghigh = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            slot_used[i] = 1'b0;
            slot_code[i] = '0;
            slot_lo[i]   = '0;
            slot_hi[i]   = '0;
        end
        code_pool = '{32'd0, 32'd1, '1, 32'd11, -32'sd11, 32'd13, -32'sd13, 32'd22,
                      32'd111, 32'd211, -32'sd211, 32'd321, 32'd2112, -32'sd2112,
                      32'd2212, -32'sd2212, 32'd130, 32'd310, 32'd3122, 32'd1000010020,
                      32'd1000020040, 32'd1000060120, CODE_MIN, CODE_MAX};

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed, pass mode with the reset window 0..0
        push_item(CMD_CHECK, '0, '0, '0, '0);
        push_item(CMD_CHECK, CODE_MIN, E_MAX, E_MAX, E_MAX);
        push_item(CMD_SPARE, CODE_MAX, E_MAX, E_MAX, E_MAX);  // unknown command
        push_item(CMD_SET, CODE_MIN, '0, '0, E_MAX);
        push_item(CMD_SET, CODE_MIN, '0, 24'd10, 24'd20);     // overwrite same code
        push_item(CMD_SET, CODE_MAX, '0, E_MAX, '0);          // wrapped gap
        push_item(CMD_SET, '1, '0, 24'd5, 24'd5);             // equal bounds
        for (int c = 2; c <= 14; c++) begin
            push_item(CMD_SET, CODE_BITS'(c), '0, 24'(c), 24'(c * 3));
        end
        push_item(CMD_SET, 32'd100, '0, 24'd1, 24'd9);        // table full, dropped
        drain();

        // Whitelist against the now-full table
        program_filter(MODE_WHITE, '0, '0);
        push_item(CMD_CHECK, CODE_MIN, 24'd15, '0, '0);
        push_item(CMD_CHECK, CODE_MIN, 24'd20, '0, '0);
        push_item(CMD_CHECK, CODE_MAX, '0, '0, '0);
        push_item(CMD_CHECK, 32'd100, 24'd7, '0, '0);
        drain();

        // Blacklist behind a wrapped global window, then clear
        program_filter(MODE_BLACK, 24'd100, 24'd50);
        push_item(CMD_CHECK, CODE_MIN, 24'd15, '0, '0);
        push_item(CMD_CHECK, CODE_MIN, 24'd75, '0, '0);
        push_item(CMD_CLEAR, '0, '0, '0, '0);
        push_item(CMD_CHECK, CODE_MIN, 24'd15, '0, '0);
        drain();

        // Undefined mode behaves as pass
        program_filter(MODE_SPARE, E_MAX, E_MAX);
        push_item(CMD_CHECK, 32'd22, 24'd12345, '0, '0);
        drain();

        // Random phases, each under its own register setting
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin mode = MODE_WHITE; glo = '0;    ghi = '0;    end
                1: begin mode = MODE_BLACK; glo = '0;    ghi = '0;    end
                2: begin mode = MODE_PASS;  glo = '0;    ghi = E_MAX; end
                3: begin mode = MODE_BLACK; glo = E_MAX; ghi = E_MAX; end
                4: begin
                    mode = MODE_WHITE;
                    glo  = ENERGY_BITS'($urandom_range(0, 24'h3F_FFFF));
                    ghi  = glo + 24'h80_0000;
                end
                5: begin
                    mode = MODE_BLACK;
                    ghi  = ENERGY_BITS'($urandom_range(0, 24'h3F_FFFF));
                    glo  = ghi + 24'h80_0000;
                end
                6: begin
                    mode = MODE_SPARE;
                    glo  = ENERGY_BITS'($urandom());
                    ghi  = ENERGY_BITS'($urandom());
                end
                7: begin mode = MODE_WHITE; glo = 24'd1; ghi = E_MAX; end
                8: begin
                    mode = MODE_PASS;
                    glo  = ENERGY_BITS'($urandom());
                    ghi  = ENERGY_BITS'($urandom());
                end
                default: begin mode = MODE_WHITE; glo = '0; ghi = '0; end
            endcase
            if (p == 6) begin
                // index with no register behind it: must change nothing
                write_reg(CFG_SPARE, CFG_DATA_W'($urandom()));
            end
            program_filter(mode, glo, ghi);

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 58) begin
                    push_item(CMD_CHECK, pick_code(), pick_energy(),
                              ENERGY_BITS'($urandom()), ENERGY_BITS'($urandom()));
                end else if (roll < 94) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: begin
                            wlo = ENERGY_BITS'($urandom());
                            whi = wlo + 24'($urandom_range(2, 5000));
                        end
                        4: begin wlo = ENERGY_BITS'($urandom()); whi = wlo; end
                        5: begin
                            wlo = ($urandom_range(0, 1) != 0) ? E_MAX : '0;
                            whi = ($urandom_range(0, 1) != 0) ? E_MAX : '0;
                        end
                        default: begin
                            wlo = ENERGY_BITS'($urandom());
                            whi = ENERGY_BITS'($urandom());
                        end
                    endcase
                    push_item(CMD_SET, pick_code(), ENERGY_BITS'($urandom()), wlo, whi);
                end else if (roll < 98) begin
                    push_item(CMD_CLEAR, $urandom(), ENERGY_BITS'($urandom()),
                              ENERGY_BITS'($urandom()), ENERGY_BITS'($urandom()));
                end else begin
                    push_item(CMD_SPARE, pick_code(), ENERGY_BITS'($urandom()),
                              ENERGY_BITS'($urandom()), ENERGY_BITS'($urandom()));
                end
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (pending_verdicts.size() != 0) begin
            report_mismatch($sformatf("%0d verdicts never produced", pending_verdicts.size()));
        end

        $display("covered %0d commands, %0d results: %0d hit checks (%0d passed),",
                 n_items, n_results, n_checks, n_passed);
        $display("%0d table writes (%0d dropped on a full table), %0d clears, %0d mismatches",
                 n_sets, n_full, n_clears, n_errors);
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
